FILE: design/pal_pkg.sv
// Package for the positional array list: record, transaction and cell command types.
// Also holds the operation, status and cell command codes. Depends on nothing.
package pal_pkg;

    localparam int CODE_W   = 31;
    localparam int YEAR_W   = 16;
    localparam int POS_W    = 4;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REM_AT    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SWAP      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_OPEN  = 2'd1;
    localparam logic [1:0] CELL_CLOSE = 2'd2;
    localparam logic [1:0] CELL_SWAP  = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [YEAR_W-1:0] year;
    } record_t;

    typedef struct packed {
        logic [1:0] op;
        record_t    new_rec;
    } cell_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    position_b;
        logic [CODE_W-1:0]   entry_code;
        logic [YEAR_W-1:0]   entry_year;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                removed_valid;
        logic [CODE_W-1:0]   removed_code;
        logic [YEAR_W-1:0]   removed_year;
        logic [COUNT_W-1:0]  entry_count;
    } out_t;

endpackage

FILE: design/positional_array_list.sv
// A result is registered and appears in the cycle after its transaction is accepted, held until taken.
// Throughput: one transaction per cycle while the output is not stalled; every cell shifts in parallel in that cycle.
// A new transaction is accepted while the previous result is being taken.
// Reset clears the record count and the output valid; record contents are not reset.
// Top level of the positional array list; depends on pal_pkg and pal_cell.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_t             m_data_reg;
    out_t             m_data_next;

    logic             s_fire;
    logic             full;
    logic             empty;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pa_c;
    logic [CMP_W-1:0] pb_c;
    logic [CMP_W-1:0] at_c;
    logic [IDX_W-1:0] at;
    logic [IDX_W-1:0] at_b;
    logic [1:0]       op;
    logic [STATUS_W-1:0] status;
    logic             removed;
    cell_cmd_t        cmd;
    record_t          rd_a;
    record_t          rd_b;
    record_t          cell_rec [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign cnt_c   = CMP_W'(count_reg);
    assign pa_c    = CMP_W'(s_data.position);
    assign pb_c    = CMP_W'(s_data.position_b);

    always_comb begin
        at_c    = '0;
        op      = CELL_HOLD;
        status  = ST_OK;
        removed = 1'b0;
        unique case (s_data.action)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
                if (s_data.action == ACT_INS_BACK) begin
                    at_c = cnt_c;
                end else if (s_data.action == ACT_INS_AT) begin
                    at_c = pa_c;
                end
                if (full) begin
                    status = ST_FULL;
                end else if (at_c > cnt_c) begin
                    status = ST_RANGE;
                end else begin
                    op = CELL_OPEN;
                end
            end
            ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
                if (s_data.action == ACT_REM_BACK) begin
                    at_c = cnt_c - 1'b1;
                end else if (s_data.action == ACT_REM_AT) begin
                    at_c = pa_c;
                end
                if (empty) begin
                    status = ST_EMPTY;
                end else if (at_c >= cnt_c) begin
                    status = ST_RANGE;
                end else begin
                    op      = CELL_CLOSE;
                    removed = 1'b1;
                end
            end
            ACT_SWAP: begin
                at_c = pa_c;
                if (pa_c >= cnt_c || pb_c >= cnt_c) begin
                    status = ST_RANGE;
                end else begin
                    op = CELL_SWAP;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign at   = at_c[IDX_W-1:0];
    assign at_b = pb_c[IDX_W-1:0];

    always_comb begin
        rd_a = '0;
        rd_b = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (at == IDX_W'(i)) begin
                rd_a = cell_rec[i];
            end
            if (at_b == IDX_W'(i)) begin
                rd_b = cell_rec[i];
            end
        end
    end

    assign cmd.op              = s_fire ? op : CELL_HOLD;
    assign cmd.new_rec.code    = s_data.entry_code;
    assign cmd.new_rec.year    = s_data.entry_year;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        record_t lower_rec;
        record_t upper_rec;
        if (g == 0) begin : g_first
            assign lower_rec = cmd.new_rec;
        end else begin : g_mid_lo
            assign lower_rec = cell_rec[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign upper_rec = cell_rec[g];
        end else begin : g_mid_hi
            assign upper_rec = cell_rec[g+1];
        end
        pal_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .at        (at),
            .at_b      (at_b),
            .lower_rec (lower_rec),
            .upper_rec (upper_rec),
            .rd_a      (rd_a),
            .rd_b      (rd_b),
            .rec       (cell_rec[g])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (op == CELL_OPEN) begin
            count_next = count_reg + 1'b1;
        end else if (op == CELL_CLOSE) begin
            count_next = count_reg - 1'b1;
        end
        m_data_next.status        = status;
        m_data_next.removed_valid = removed;
        m_data_next.removed_code  = removed ? rd_a.code : '0;
        m_data_next.removed_year  = removed ? rd_a.year : '0;
        m_data_next.entry_count   = COUNT_W'(count_next);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Record count exceeds the capacity.");

    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.removed_valid |-> m_data.status == ST_OK)
        else $error("A removed record was returned with a failing status.");

    a_empty_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && empty && (s_data.action == ACT_REM_FRONT || s_data.action == ACT_REM_BACK
        || s_data.action == ACT_REM_AT) |=> m_valid && m_data.status == ST_EMPTY
        && count_reg == '0)
        else $error("A remove from an empty list was not rejected.");

    a_close_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op == CELL_CLOSE |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("A removal did not reduce the record count by one.");
`endif

endmodule

FILE: design/pal_cell.sv
// One cell of the list: holds the record at a fixed position and shifts with its neighbours.
// Depends on pal_pkg for the record and cell command types.
module pal_cell
    import pal_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] at,
    input  logic [IDX_W-1:0] at_b,
    input  record_t          lower_rec,
    input  record_t          upper_rec,
    input  record_t          rd_a,
    input  record_t          rd_b,
    output record_t          rec
);

    localparam logic [IDX_W-1:0] IDX = IDX_W'(CELL_IDX);

    record_t rec_reg;
    record_t rec_next;

    always_comb begin
        rec_next = rec_reg;
        unique case (cmd.op)
            CELL_HOLD: begin
                rec_next = rec_reg;
            end
            CELL_OPEN: begin
                if (at == IDX) begin
                    rec_next = cmd.new_rec;
                end else if (at < IDX) begin
                    rec_next = lower_rec;
                end
            end
            CELL_CLOSE: begin
                if (at <= IDX) begin
                    rec_next = upper_rec;
                end
            end
            CELL_SWAP: begin
                if (at == IDX) begin
                    rec_next = rd_b;
                end else if (at_b == IDX) begin
                    rec_next = rd_a;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule
